FILE: rtl/core/clc_pkg.sv
package clc_pkg;

  localparam int unsigned ClcMaxAtoms = 1024;
  localparam int unsigned CoordW      = 23;
  localparam int unsigned TypeW       = 8;
  localparam int unsigned AtomW       = TypeW + 3 * CoordW;
  localparam int unsigned CutW        = 48;
  localparam int unsigned IdxW        = 10;
  localparam int unsigned SizeOutW    = 11;

  typedef enum logic [1:0] {
    CmdLoad  = 2'd0,
    CmdRun   = 2'd1,
    CmdQuery = 2'd2,
    CmdBad   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StLoaded = 2'd0,
    StDone   = 2'd1,
    StAnswer = 2'd2,
    StError  = 2'd3
  } status_e;

  typedef enum logic [7:0] {
    RegCutoffSq  = 8'd0,
    RegTypeA     = 8'd1,
    RegTypeB     = 8'd2,
    RegBoxLength = 8'd3
  } reg_e;

  typedef enum logic [3:0] {
    SIdle, SQres, SInit, SKrd, SKchk, SIrd, SIlat, SJrd, SJchk, SJwait,
    SJw1, SJw2, SSrd, SSwr, SDone
  } state_e;

  typedef struct packed {
    logic atom;
    logic link;
    logic size;
  } mem_we_t;

  // Minimum-image fold of one axis difference, returned as a magnitude.
  function automatic logic [23:0] fold_mag(logic [CoordW-1:0] a, logic [CoordW-1:0] b,
                                           logic [CoordW-1:0] len);
    logic signed [25:0] d;
    logic signed [25:0] l;
    d = signed'({3'b000, a}) - signed'({3'b000, b});
    l = signed'({3'b000, len});
    if ((d <<< 1) > l) begin
      d = d - l;
    end else if ((d <<< 1) < -l) begin
      d = d + l;
    end
    if (d < 0) begin
      d = -d;
    end
    return d[23:0];
  endfunction

endpackage

FILE: rtl/core/clc_store.sv
module clc_store #(
  parameter int unsigned AW = 10,
  parameter int unsigned SW = 11
) (
  input  logic                   clk_i,
  input  clc_pkg::mem_we_t       we_i,
  input  logic [AW-1:0]          wr_addr_i,
  input  logic [clc_pkg::AtomW-1:0] atom_wd_i,
  input  logic [AW-1:0]          link_wd_i,
  input  logic [SW-1:0]          size_wd_i,
  input  logic [AW-1:0]          rd_addr_i,
  output logic [clc_pkg::AtomW-1:0] atom_rd_o,
  output logic [AW-1:0]          link_rd_o,
  output logic [SW-1:0]          size_rd_o
);
  import clc_pkg::*;

  localparam int unsigned Depth = 2 ** AW;

  logic [AtomW-1:0] atom_mem [Depth];
  logic [AW-1:0]    link_mem [Depth];
  logic [SW-1:0]    size_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i.atom) begin
      atom_mem[wr_addr_i] <= atom_wd_i;
    end
    atom_rd_o <= atom_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.link) begin
      link_mem[wr_addr_i] <= link_wd_i;
    end
    link_rd_o <= link_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.size) begin
      size_mem[wr_addr_i] <= size_wd_i;
    end
    size_rd_o <= size_mem[rd_addr_i];
  end

endmodule

FILE: rtl/core/clc_dist.sv
module clc_dist (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [clc_pkg::AtomW-1:0] atom_p_i,
  input  logic [clc_pkg::AtomW-1:0] atom_q_i,
  input  logic [clc_pkg::CutW-1:0] cutoff_sq_i,
  input  logic [clc_pkg::TypeW-1:0] type_a_i,
  input  logic [clc_pkg::TypeW-1:0] type_b_i,
  input  logic [clc_pkg::CoordW-1:0] box_len_i,
  output logic                     valid_o,
  output logic                     linked_o
);
  import clc_pkg::*;

  logic [2:0]  vld_q;
  logic [23:0] mag_q [3];
  logic [47:0] sq_q [3];
  logic        tok1_q, tok2_q, link_q;
  logic [TypeW-1:0] tp, tq;
  logic [49:0] sum;

  assign tp = atom_p_i[TypeW-1:0];
  assign tq = atom_q_i[TypeW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i};
    end
  end

  // fold, square, then sum and compare, one register stage each
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      mag_q[a] <= fold_mag(atom_p_i[TypeW + a*CoordW +: CoordW],
                           atom_q_i[TypeW + a*CoordW +: CoordW], box_len_i);
      sq_q[a]  <= mag_q[a] * mag_q[a];
    end
    tok1_q <= (tp == type_a_i && tq == type_b_i) || (tp == type_b_i && tq == type_a_i);
    tok2_q <= tok1_q;
    link_q <= tok2_q && (sum <= {2'b00, cutoff_sq_i});
  end

  assign sum      = {2'b00, sq_q[0]} + {2'b00, sq_q[1]} + {2'b00, sq_q[2]};
  assign valid_o  = vld_q[2];
  assign linked_o = link_q;

endmodule

FILE: rtl/core/cutoff_cluster_size_labeler.sv
// Cluster labeler over a periodic box. Loads (cmd 0) store one atom per beat and answer in
// the next cycle; queries (cmd 2) are answered from the registered size memory in SQres. A run
// (cmd 1) holds s_axis_tready low while a sequencer walks the stores: it resets the chains,
// then for every chain root reads each candidate pair (memory read, 3-stage distance pipe),
// splices in each linked atom (SJw1, SJw2), and walks the chain (SSrd, SSwr) to write sizes;
// the run is bound by the single read port of the atom, chain and size memories. Results
// leave through a one-beat output register; a new beat is taken only when that register is
// empty or its result leaves in the same cycle.
// Configuration writes are always taken; issue them only while no beat is in flight.
module cutoff_cluster_size_labeler
  import clc_pkg::*;
#(
  parameter int unsigned MAX_ATOMS = ClcMaxAtoms
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // atom_type, pos_x, pos_y, pos_z, query_index
  input  logic [1:0]  s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // atom_index, cluster_size
  output logic [1:0]  m_axis_tuser,  // status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_ATOMS);
  localparam int unsigned CW = $clog2(MAX_ATOMS + 1);
  localparam int unsigned SW = CW;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_ATOMS);

  // configuration registers
  logic [CutW-1:0]   cutoff_q;
  logic [TypeW-1:0]  type_a_q, type_b_q;
  logic [CoordW-1:0] box_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= 48'd16777216;
      type_a_q <= '0;
      type_b_q <= '0;
      box_q    <= 23'd8388607;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegCutoffSq:  cutoff_q <= cfg_data_i;
        RegTypeA:     type_a_q <= cfg_data_i[TypeW-1:0];
        RegTypeB:     type_b_q <= cfg_data_i[TypeW-1:0];
        RegBoxLength: box_q    <= cfg_data_i[CoordW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  state_e            state_q, state_d;
  logic [CW-1:0]     n_q, n_d, k_q, k_d, j_q, j_d;
  logic [AW-1:0]     i_q, i_d, li_q, li_d;
  logic [SW-1:0]     cnt_q, cnt_d;
  logic              clus_q, clus_d;
  logic [IdxW-1:0]   qidx_q, qidx_d;
  logic [AtomW-1:0]  ai_q, ai_d;

  // output register
  logic              ov_q, ov_d;
  logic [1:0]        ou_q, ou_d;
  logic [23:0]       od_q, od_d;

  // memory port
  mem_we_t           we;
  logic [AW-1:0]     wr_addr, rd_addr, link_wd;
  logic [SW-1:0]     size_wd;
  logic [AtomW-1:0]  atom_rd;
  logic [AW-1:0]     link_rd;
  logic [SW-1:0]     size_rd;
  logic              dist_start, dist_valid, dist_link;

  logic              accept;
  cmd_e              cmd;
  logic [IdxW-1:0]   q_in;
  logic [IdxW+AW-1:0] q_ext;
  logic [IdxW+CW-1:0] q_cmp, n_cmp, slot_ext;
  logic [SW+SizeOutW-1:0] size_ext;

  assign cmd      = cmd_e'(s_axis_tuser);
  assign q_in     = s_axis_tdata[86:77];
  assign q_ext    = {{AW{1'b0}}, q_in};
  assign q_cmp    = {{CW{1'b0}}, qidx_q};
  assign n_cmp    = {{IdxW{1'b0}}, n_q};
  assign slot_ext = {{IdxW{1'b0}}, n_q};
  assign size_ext = {{SizeOutW{1'b0}}, size_rd};
  assign s_axis_tready = (state_q == SIdle) && (!ov_q || m_axis_tready);
  assign accept   = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = ou_q;
  assign m_axis_tdata  = od_q;

  clc_store #(.AW(AW), .SW(SW)) u_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .wr_addr_i (wr_addr),
    .atom_wd_i (s_axis_tdata[AtomW-1:0]),
    .link_wd_i (link_wd),
    .size_wd_i (size_wd),
    .rd_addr_i (rd_addr),
    .atom_rd_o (atom_rd),
    .link_rd_o (link_rd),
    .size_rd_o (size_rd)
  );

  clc_dist u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (dist_start),
    .atom_p_i    (ai_q),
    .atom_q_i    (atom_rd),
    .cutoff_sq_i (cutoff_q),
    .type_a_i    (type_a_q),
    .type_b_i    (type_b_q),
    .box_len_i   (box_q),
    .valid_o     (dist_valid),
    .linked_o    (dist_link)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      n_q     <= '0;
      clus_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      clus_q  <= clus_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    j_q    <= j_d;
    i_q    <= i_d;
    li_q   <= li_d;
    cnt_q  <= cnt_d;
    qidx_q <= qidx_d;
    ai_q   <= ai_d;
    ou_q   <= ou_d;
    od_q   <= od_d;
  end

  always_comb begin
    state_d = state_q;
    n_d = n_q; k_d = k_q; j_d = j_q; i_d = i_q; li_d = li_q;
    cnt_d = cnt_q; clus_d = clus_q; qidx_d = qidx_q; ai_d = ai_q;
    ov_d = ov_q && !m_axis_tready;
    ou_d = ou_q; od_d = od_q;
    we = '0;
    wr_addr = i_q;
    rd_addr = i_q;
    link_wd = j_q[AW-1:0];
    size_wd = cnt_q;
    dist_start = 1'b0;

    case (state_q)
      SIdle: begin
        if (accept) begin
          ov_d = 1'b1;
          od_d = '0;
          ou_d = StError;
          case (cmd)
            CmdLoad: begin
              if (n_q < MaxCnt) begin
                we.atom = 1'b1;
                wr_addr = n_q[AW-1:0];
                n_d     = n_q + 1'b1;
                clus_d  = 1'b0;
                ou_d    = StLoaded;
                od_d    = {14'd0, slot_ext[IdxW-1:0]};
              end
            end
            CmdRun: begin
              ov_d    = 1'b0;
              j_d     = '0;
              state_d = SInit;
            end
            CmdQuery: begin
              ov_d    = 1'b0;
              qidx_d  = q_in;
              rd_addr = q_ext[AW-1:0];
              state_d = SQres;
            end
            default: ;
          endcase
        end
      end
      SQres: begin
        ov_d = 1'b1;
        if (clus_q && q_cmp < n_cmp) begin
          ou_d = StAnswer;
          od_d = {3'd0, (size_ext > (SW+SizeOutW)'(2047)) ? 11'h7FF : size_ext[SizeOutW-1:0],
                  qidx_q};
        end else begin
          ou_d = StError;
          od_d = {14'd0, qidx_q};
        end
        state_d = SIdle;
      end
      // reset every chain to a single member
      SInit: begin
        if (j_q < n_q) begin
          we.link = 1'b1;
          wr_addr = j_q[AW-1:0];
          j_d     = j_q + 1'b1;
        end else begin
          k_d     = '0;
          state_d = SKrd;
        end
      end
      SKrd: begin
        rd_addr = k_q[AW-1:0];
        state_d = (k_q < n_q) ? SKchk : SDone;
      end
      // skip atoms already taken into an earlier chain
      SKchk: begin
        if (link_rd != k_q[AW-1:0]) begin
          k_d     = k_q + 1'b1;
          state_d = SKrd;
        end else begin
          i_d     = k_q[AW-1:0];
          cnt_d   = SW'(1);
          state_d = SIrd;
        end
      end
      SIrd: begin
        rd_addr = i_q;
        j_d     = k_q + 1'b1;
        state_d = SIlat;
      end
      SIlat: begin
        ai_d    = atom_rd;
        li_d    = link_rd;
        state_d = SJrd;
      end
      SJrd: begin
        if (j_q < n_q) begin
          rd_addr = j_q[AW-1:0];
          state_d = SJchk;
        end else if (li_q == k_q[AW-1:0]) begin
          i_d     = k_q[AW-1:0];
          state_d = SSrd;
        end else begin
          i_d     = li_q;
          state_d = SIrd;
        end
      end
      SJchk: begin
        if (link_rd != j_q[AW-1:0]) begin
          j_d     = j_q + 1'b1;
          state_d = SJrd;
        end else begin
          dist_start = 1'b1;
          state_d    = SJwait;
        end
      end
      SJwait: begin
        if (dist_valid) begin
          if (dist_link) begin
            state_d = SJw1;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = SJrd;
          end
        end
      end
      // splice j in behind i
      SJw1: begin
        we.link = 1'b1;
        wr_addr = j_q[AW-1:0];
        link_wd = li_q;
        state_d = SJw2;
      end
      SJw2: begin
        we.link = 1'b1;
        wr_addr = i_q;
        link_wd = j_q[AW-1:0];
        li_d    = j_q[AW-1:0];
        cnt_d   = cnt_q + 1'b1;
        j_d     = j_q + 1'b1;
        state_d = SJrd;
      end
      // walk the finished chain and write its size to each member
      SSrd: begin
        rd_addr = i_q;
        state_d = SSwr;
      end
      SSwr: begin
        we.size = 1'b1;
        wr_addr = i_q;
        i_d     = link_rd;
        if (link_rd == k_q[AW-1:0]) begin
          k_d     = k_q + 1'b1;
          state_d = SKrd;
        end else begin
          state_d = SSrd;
        end
      end
      SDone: begin
        ov_d    = 1'b1;
        ou_d    = StDone;
        od_d    = '0;
        clus_d  = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) n_q <= MaxCnt)
    else $error("atom count beyond capacity");
  a_splice_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SJw2 |-> $past(state_q) == SJw1)
    else $error("chain splice not in two steps");
  a_query_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd == CmdQuery |=> state_q == SQres)
    else $error("query did not reach answer step");
  a_run_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SDone |=> clus_q && ov_q)
    else $error("run end did not set flag and result");

endmodule

FILE: tb/cutoff_cluster_size_labeler_tb.sv
`timescale 1ns / 100ps

module cutoff_cluster_size_labeler_tb;
  import clc_pkg::*;

  localparam int unsigned CycleLimit = 25000000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned Settle     = 20;

  // One expected response beat from the labeler.
  typedef struct {
    status_e     status;
    logic [9:0]  atom_index;
    logic [10:0] cluster_size;
  } cluster_result_t;

  // Mirror of the labeler: keeps its own atom store and chain table, and a queue of
  // responses still owed by the block.
  class cluster_scoreboard;
    logic [47:0]       cutoff_sq;
    logic [7:0]        type_a;
    logic [7:0]        type_b;
    logic [22:0]       box_len;
    logic [22:0]       pos_x[ClcMaxAtoms];
    logic [22:0]       pos_y[ClcMaxAtoms];
    logic [22:0]       pos_z[ClcMaxAtoms];
    logic [7:0]        kind[ClcMaxAtoms];
    int unsigned       chain[ClcMaxAtoms];
    int unsigned       size_of[ClcMaxAtoms];
    bit                seen[ClcMaxAtoms];
    int unsigned       n_atoms;
    bit                clustered;
    cluster_result_t   owed[$];
    int unsigned       errors;

    function new();
      cutoff_sq = 48'd16777216;
      type_a    = 8'd0;
      type_b    = 8'd0;
      box_len   = 23'd8388607;
      n_atoms   = 0;
      clustered = 1'b0;
      errors    = 0;
    endfunction

    function void set_reg(reg_e r, logic [47:0] v);
      case (r)
        RegCutoffSq:  cutoff_sq = v;
        RegTypeA:     type_a    = v[7:0];
        RegTypeB:     type_b    = v[7:0];
        RegBoxLength: box_len   = v[22:0];
        default: ;
      endcase
    endfunction

    // Squared minimum-image difference along one axis.
    function longint unsigned axis_sq(logic [22:0] a, logic [22:0] b);
      longint d;
      longint len;
      d   = longint'(a) - longint'(b);
      len = longint'(box_len);
      if (2 * d > len) begin
        d = d - len;
      end else if (2 * d < -len) begin
        d = d + len;
      end
      if (d < 0) begin
        d = -d;
      end
      return longint'(d) * longint'(d);
    endfunction

    function bit atoms_bond(int unsigned p, int unsigned q);
      longint unsigned s;
      if (!((kind[p] == type_a && kind[q] == type_b) ||
            (kind[p] == type_b && kind[q] == type_a))) begin
        return 1'b0;
      end
      s = axis_sq(pos_x[p], pos_x[q]) + axis_sq(pos_y[p], pos_y[q]) +
          axis_sq(pos_z[p], pos_z[q]);
      return s <= longint'(cutoff_sq);
    endfunction

    // Grow each root's ring by splicing in every free atom bonded to a member,
    // then stamp the ring length onto every member.
    function void build_clusters();
      int unsigned i;
      int unsigned j;
      int unsigned cnt;
      for (int unsigned k = 0; k < n_atoms; k++) begin
        chain[k] = k;
      end
      for (int unsigned k = 0; k < n_atoms; k++) begin
        if (chain[k] != k) continue;
        i = k;
        do begin
          for (j = k + 1; j < n_atoms; j++) begin
            if (chain[j] != j) continue;
            if (atoms_bond(i, j)) begin
              chain[j] = chain[i];
              chain[i] = j;
            end
          end
          i = chain[i];
        end while (i != k);
      end
      for (i = 0; i < n_atoms; i++) begin
        seen[i] = 1'b0;
      end
      for (i = 0; i < n_atoms; i++) begin
        if (seen[i]) continue;
        cnt = 1;
        for (j = chain[i]; j != i; j = chain[j]) begin
          cnt++;
        end
        j = i;
        do begin
          size_of[j] = cnt;
          seen[j]    = 1'b1;
          j          = chain[j];
        end while (j != i);
      end
      clustered = 1'b1;
    endfunction

    function void note_input(cmd_e c, logic [87:0] d);
      cluster_result_t r;
      logic [9:0] q;
      q              = d[86:77];
      r.status       = StError;
      r.atom_index   = '0;
      r.cluster_size = '0;
      case (c)
        CmdLoad: begin
          if (n_atoms < ClcMaxAtoms) begin
            kind[n_atoms]  = d[7:0];
            pos_x[n_atoms] = d[30:8];
            pos_y[n_atoms] = d[53:31];
            pos_z[n_atoms] = d[76:54];
            r.status       = StLoaded;
            r.atom_index   = n_atoms[9:0];
            n_atoms++;
            clustered = 1'b0;
          end
        end
        CmdRun: begin
          build_clusters();
          r.status = StDone;
        end
        CmdQuery: begin
          r.atom_index = q;
          if (clustered && q < n_atoms) begin
            r.status       = StAnswer;
            r.cluster_size = (size_of[q] > 2047) ? 11'd2047 : size_of[q][10:0];
          end
        end
        default: ;
      endcase
      owed.insert(owed.size(), r);
    endfunction

    function void check_result(logic [1:0] st, logic [23:0] d);
      cluster_result_t r;
      if (owed.size() == 0) begin
        $error("unexpected response beat: status %0d data %h", st, d);
        errors++;
        return;
      end
      r = owed.pop_front();
      if (st !== r.status) begin
        $error("status expected %0d actual %0d", r.status, st);
        errors++;
      end
      if (d[9:0] !== r.atom_index) begin
        $error("atom_index expected %0d actual %0d", r.atom_index, d[9:0]);
        errors++;
      end
      if (d[20:10] !== r.cluster_size) begin
        $error("cluster_size expected %0d actual %0d", r.cluster_size, d[20:10]);
        errors++;
      end
      if (d[23:21] !== 3'b000) begin
        $error("tdata padding expected 0 actual %0d", d[23:21]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata  = '0;  // atom_type, pos_x, pos_y, pos_z, query_index
  logic [1:0]  s_axis_tuser  = CmdLoad;  // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;  // atom_index, cluster_size
  logic [1:0]  m_axis_tuser;  // status
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i   = '0;
  logic [47:0] cfg_data_i    = '0;

  cluster_scoreboard sb = new();

  int unsigned send_idle = 29;
  int unsigned recv_idle = 79;
  bit          hold_req  = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycles    = 0;

  cutoff_cluster_size_labeler u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog: a stuck run or a lost response ends here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("cutoff_cluster_size_labeler_tb: errors");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request so the
  // output register fills and the block has to stall its input.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req      = 1'b0;
      hold_left     = HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Sample responses on the falling edge before the rising edge that takes them, clear of
  // any update made at that edge.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  function automatic logic [87:0] pack_beat(logic [7:0] kind, logic [22:0] x,
                                            logic [22:0] y, logic [22:0] z,
                                            logic [9:0] q);
    return {1'b0, q, z, y, x, kind};
  endfunction

  // Drive one beat and return on the edge that takes it.
  task automatic send_beat(cmd_e c, logic [87:0] d);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= d;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    sb.note_input(c, d);
  endtask

  task automatic send_load(logic [7:0] kind, logic [22:0] x, logic [22:0] y,
                           logic [22:0] z);
    send_beat(CmdLoad, pack_beat(kind, x, y, z, 10'($urandom)));
  endtask

  // Non-load commands carry random filler in the unused atom fields.
  task automatic send_cmd(cmd_e c, logic [9:0] q);
    send_beat(c, pack_beat(8'($urandom), 23'($urandom), 23'($urandom), 23'($urandom), q));
  endtask

  // Drop valid, let every owed response drain, then let the pipe settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e r, logic [47:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= v;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.set_reg(r, v);
    @(posedge clk_i);
  endtask

  function automatic logic [22:0] rand_coord();
    if ($urandom_range(9) < 8 && sb.box_len > 1) begin
      return 23'($urandom_range(sb.box_len - 1));
    end
    return 23'($urandom);
  endfunction

  function automatic logic [7:0] rand_kind();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 4) return sb.type_a;
    if (r < 8) return sb.type_b;
    return 8'($urandom);
  endfunction

  function automatic logic [9:0] rand_query();
    if (sb.n_atoms > 0 && $urandom_range(9) != 0) begin
      return 10'($urandom_range(sb.n_atoms - 1));
    end
    return 10'($urandom);
  endfunction

  logic [47:0] cut_tab[4] = '{48'd150994944, 48'd0, 48'hFFFF_FFFF_FFFF, 48'd67108864};
  logic [7:0]  ta_tab[4]  = '{8'd1, 8'd3, 8'd0, 8'd255};
  logic [7:0]  tb_tab[4]  = '{8'd2, 8'd3, 8'd255, 8'd0};
  logic [22:0] box_tab[4] = '{23'd65536, 23'd1, 23'd8388607, 23'd32768};

  initial begin
    int unsigned n;
    int unsigned r;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reset settings, cutoff distance of exactly 4096, box at its maximum.
    send_cmd(CmdQuery, 10'd0);            // query before any run
    send_cmd(CmdRun, 10'd0);              // run on an empty store
    send_cmd(CmdQuery, 10'd0);            // index not loaded
    send_cmd(CmdBad, 10'd1023);           // unknown command
    send_load(8'd0, 23'd0, 23'd0, 23'd0);
    send_load(8'd0, 23'd4096, 23'd0, 23'd0);  // distance equal to cutoff links
    send_load(8'd0, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF);  // wraps onto atom 0
    send_load(8'd255, 23'd0, 23'd0, 23'd0);   // wrong type stays alone
    send_load(8'd0, 23'h400000, 23'h2AAAAA, 23'h555555);
    send_cmd(CmdQuery, 10'd1);            // stale: load since last run
    send_cmd(CmdRun, 10'd0);
    for (int unsigned i = 0; i < 6; i++) begin
      send_cmd(CmdQuery, 10'(i));        // index 5 not loaded
    end
    send_cmd(CmdQuery, 10'd1023);
    send_cmd(CmdRun, 10'd0);              // second run with no new loads
    send_cmd(CmdQuery, 10'd2);
    drain();

    for (int unsigned p = 0; p < 4; p++) begin
      write_reg(RegCutoffSq, cut_tab[p]);
      write_reg(RegTypeA, ta_tab[p]);
      write_reg(RegTypeB, tb_tab[p]);
      write_reg(RegBoxLength, box_tab[p]);
      case (p)
        0: begin send_idle = 29; recv_idle = 79; end
        1: begin send_idle = 79; recv_idle = 29; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int unsigned round = 0; round < 10; round++) begin
        n = $urandom_range(6);
        for (int unsigned i = 0; i < n; i++) begin
          if ($urandom_range(9) == 0) begin
            send_cmd(CmdQuery, rand_query());  // query among loads, stale once a load of the round has gone in
          end
          send_load(rand_kind(), rand_coord(), rand_coord(), rand_coord());
        end
        send_cmd(CmdRun, 10'($urandom));
        if (p == 2 && round == 0) begin
          hold_req = 1'b1;
        end
        n = $urandom_range(4, 14);
        for (int unsigned i = 0; i < n; i++) begin
          r = $urandom_range(99);
          if (r < 8) begin
            send_cmd(CmdBad, 10'($urandom));
          end else if (r < 18) begin
            send_cmd(CmdQuery, 10'($urandom));
          end else begin
            send_cmd(CmdQuery, rand_query());
          end
        end
      end
      drain();
    end

    // Two loads at the extremes, then a query past the store and an unknown command.
    send_load(8'hFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF);
    send_load(8'h00, 23'd0, 23'd0, 23'd0);
    send_cmd(CmdQuery, 10'd1023);
    send_cmd(CmdBad, 10'd0);
    drain();
    repeat (50) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("cutoff_cluster_size_labeler_tb: clean");
    end else begin
      $display("cutoff_cluster_size_labeler_tb: errors");
    end
    $finish;
  end

endmodule
